>>> src/stt_pkg.sv
// ----------------------------------------------------------------------------
// Software timer table package
// Shared slot record, action and status codes, and sizing constants.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int MAX_TIMERS = 8;
   localparam int SLOT_W     = 3;
   localparam int COUNT_W    = 16;
   localparam int SCALE_W    = 8;
   localparam int ACTION_W   = 3;
   localparam int STATUS_W   = 2;

   localparam logic [ACTION_W-1:0] ACT_TICK     = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_START    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_STOP     = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_DISPATCH = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

   typedef struct packed {
      logic               active;
      logic               periodic;
      logic [COUNT_W-1:0] remaining;
      logic [COUNT_W-1:0] reload;
   } slot_rec_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

>>> src/stt_cell.sv
// ----------------------------------------------------------------------------
// Timer slot cell
// Holds one slot record and takes its neighbor's record on every shift.
// ----------------------------------------------------------------------------
module stt_cell
   import stt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         shift_en,
   input  slot_rec_type rec_in,
   output slot_rec_type rec_out
);

   logic               active_ff;
   logic               periodic_ff;
   logic [COUNT_W-1:0] remaining_ff;
   logic [COUNT_W-1:0] reload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (shift_en) begin
         active_ff <= rec_in.active;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         periodic_ff  <= rec_in.periodic;
         remaining_ff <= rec_in.remaining;
         reload_ff    <= rec_in.reload;
      end
   end

   always_comb begin
      rec_out.active    = active_ff;
      rec_out.periodic  = periodic_ff;
      rec_out.remaining = remaining_ff;
      rec_out.reload    = reload_ff;
   end

endmodule

>>> src/stt_ctrl.sv
// ----------------------------------------------------------------------------
// Timer table controller
// Sequences one ring rotation per action, updates the slot at the head of the
// ring, runs the prescaler and drives the result word register.
// ----------------------------------------------------------------------------
module stt_ctrl
   import stt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [SLOT_W-1:0]   req_slot_id,
   input  logic [COUNT_W-1:0]  req_delay_value,
   input  logic                req_is_periodic,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot_out,
   output logic                rsp_fired,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [SCALE_W-1:0]  csr_ticks_per_decrement,
   input  slot_rec_type        head_rec,
   output slot_rec_type        tail_rec,
   output logic                shift_en
);

   state_type state_ff, state_in;

   logic [ACTION_W-1:0] op_ff;
   logic [SLOT_W-1:0]   sid_ff;
   logic [COUNT_W-1:0]  delay_ff;
   logic                periodic_ff;
   logic                dec_ff, dec_in;
   logic                found_ff, found_in;
   logic [SLOT_W-1:0]   first_ff, first_in;
   logic                stop_ok_ff, stop_ok_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]   pend_slot_ff, pend_slot_in;
   logic [SLOT_W-1:0]   scan_ff, scan_in;
   logic [SCALE_W-1:0]  tpd_ff;
   logic [SCALE_W-1:0]  presc_ff, presc_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                rsp_fired_ff;
   logic                rsp_last_ff;

   logic                accept;
   logic                out_free;
   logic                fire;
   logic                step;
   logic                last_step;
   logic                mid_push;
   logic                final_push;
   logic [SCALE_W-1:0]  setting;
   logic [SCALE_W:0]    presc_next;

   logic [STATUS_W-1:0] fin_status;
   logic [SLOT_W-1:0]   fin_slot;
   logic                fin_fired;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_step = (scan_ff == SLOT_W'(MAX_TIMERS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (step && last_step) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // scan control and result selection
   always_comb begin
      fire = (state_ff == ST_SCAN) && (op_ff == ACT_DISPATCH) &&
             head_rec.active && (head_rec.remaining == '0);
      // hold the ring while an earlier expired slot cannot be handed on
      step       = (state_ff == ST_SCAN) && !(fire && pend_valid_ff && !out_free);
      mid_push   = (state_ff == ST_SCAN) && fire && pend_valid_ff && out_free;
      final_push = (state_ff == ST_DONE) && out_free;
      shift_en   = step;

      fin_status = STAT_OK;
      fin_slot   = '0;
      fin_fired  = 1'b0;
      unique case (op_ff) inside
         ACT_TICK, ACT_CLEAR: begin
            fin_status = STAT_OK;
         end
         ACT_START: begin
            if (!found_ff) begin
               fin_status = STAT_FULL;
            end else if (delay_ff == '0) begin
               fin_status = STAT_INVALID;
            end else begin
               fin_slot = first_ff;
            end
         end
         ACT_STOP: begin
            fin_status = stop_ok_ff ? STAT_OK : STAT_INVALID;
         end
         ACT_DISPATCH: begin
            if (pend_valid_ff) begin
               fin_slot  = pend_slot_ff;
               fin_fired = 1'b1;
            end
         end
         default: fin_status = STAT_INVALID;
      endcase
   end

   // head slot update, fed back into the tail of the ring
   always_comb begin
      tail_rec   = head_rec;
      found_in   = found_ff;
      first_in   = first_ff;
      stop_ok_in = stop_ok_ff;
      unique case (op_ff)
         ACT_TICK: begin
            if (dec_ff && head_rec.active && head_rec.remaining != '0) begin
               tail_rec.remaining = head_rec.remaining - COUNT_W'(1);
            end
         end
         ACT_START: begin
            if (!head_rec.active && !found_ff) begin
               found_in = 1'b1;
               first_in = scan_ff;
               if (delay_ff != '0) begin
                  tail_rec.active    = 1'b1;
                  tail_rec.periodic  = periodic_ff;
                  tail_rec.remaining = delay_ff;
                  tail_rec.reload    = delay_ff;
               end
            end
         end
         ACT_STOP: begin
            if (scan_ff == sid_ff && head_rec.active) begin
               tail_rec.active = 1'b0;
               stop_ok_in      = 1'b1;
            end
         end
         ACT_DISPATCH: begin
            if (head_rec.active && head_rec.remaining == '0) begin
               tail_rec.remaining = head_rec.reload;
               tail_rec.active    = head_rec.periodic;
            end
         end
         ACT_CLEAR: begin
            tail_rec.active = 1'b0;
         end
         default: tail_rec = head_rec;
      endcase
   end

   // prescaler, evaluated when a tick is taken
   always_comb begin
      setting    = (tpd_ff == '0) ? SCALE_W'(1) : tpd_ff;
      presc_next = {1'b0, presc_ff} + (SCALE_W+1)'(1);
      presc_in   = presc_ff;
      dec_in     = dec_ff;
      if (accept && req_action == ACT_TICK) begin
         if (presc_next >= {1'b0, setting}) begin
            presc_in = '0;
            dec_in   = 1'b1;
         end else begin
            presc_in = presc_next[SCALE_W-1:0];
            dec_in   = 1'b0;
         end
      end
   end

   always_comb begin
      scan_in       = step ? scan_ff + SLOT_W'(1) : scan_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      if (accept) begin
         pend_valid_in = 1'b0;
         scan_in       = '0;
      end else if (step && fire) begin
         pend_valid_in = 1'b1;
         pend_slot_in  = scan_ff;
      end
      if (mid_push || final_push) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tpd_ff        <= SCALE_W'(1);
         presc_ff      <= '0;
         dec_ff        <= 1'b0;
         scan_ff       <= '0;
         pend_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         stop_ok_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         presc_ff      <= presc_in;
         dec_ff        <= dec_in;
         scan_ff       <= scan_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            tpd_ff <= csr_ticks_per_decrement;
         end
         if (accept) begin
            found_ff   <= 1'b0;
            stop_ok_ff <= 1'b0;
         end else if (step) begin
            found_ff   <= found_in;
            stop_ok_ff <= stop_ok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      if (accept) begin
         op_ff       <= req_action;
         sid_ff      <= req_slot_id;
         delay_ff    <= req_delay_value;
         periodic_ff <= req_is_periodic;
      end
      if (step) begin
         first_ff <= first_in;
      end
      if (mid_push) begin
         rsp_status_ff <= STAT_OK;
         rsp_slot_ff   <= pend_slot_ff;
         rsp_fired_ff  <= 1'b1;
         rsp_last_ff   <= 1'b0;
      end else if (final_push) begin
         rsp_status_ff <= fin_status;
         rsp_slot_ff   <= fin_slot;
         rsp_fired_ff  <= fin_fired;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_fired    = rsp_fired_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

>>> src/software_timer_table.sv
// ----------------------------------------------------------------------------
// Software timer table
// Eight timer slots kept in a rotating ring of cells, with a shared controller.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one action word (tick, start, stop, dispatch, clear). It is
//   taken when req_valid is high and req_stall is low. rsp_* returns result
//   words under the same valid/stall rule; rsp_last marks the final word of
//   an action. csr_* writes ticks_per_decrement while the block is idle.
//   Each action rotates the slot ring once, visiting one slot per cycle at
//   the head while the ring is not held, until all MAX_TIMERS (8) slots
//   have passed, then issues its final word; no new action word is taken
//   before then. Dispatch issues one word per expired slot, in slot
//   order; each is handed on when the next expired slot is found.
//   When rsp_stall is held, the ring stops at the next expired slot and the
//   final word waits; no word is lost. req_stall stays high until the final
//   word is in the output register.
//   Reset frees every slot, clears the prescaler and sets ticks_per_decrement
//   to 1. Slot counts and delays are not cleared.
// ----------------------------------------------------------------------------
module software_timer_table
   import stt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [SLOT_W-1:0]   req_slot_id,
   input  logic [COUNT_W-1:0]  req_delay_value,
   input  logic                req_is_periodic,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot_out,
   output logic                rsp_fired,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [SCALE_W-1:0]  csr_ticks_per_decrement
);

   slot_rec_type ring [MAX_TIMERS];
   slot_rec_type tail_rec;
   logic         shift_en;

   for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
      if (i == MAX_TIMERS - 1) begin : g_tail
         stt_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .rec_in   (tail_rec),
            .rec_out  (ring[i])
         );
      end else begin : g_body
         stt_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .rec_in   (ring[i+1]),
            .rec_out  (ring[i])
         );
      end
   end

   stt_ctrl u_ctrl (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_action              (req_action),
      .req_slot_id             (req_slot_id),
      .req_delay_value         (req_delay_value),
      .req_is_periodic         (req_is_periodic),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_status              (rsp_status),
      .rsp_slot_out            (rsp_slot_out),
      .rsp_fired               (rsp_fired),
      .rsp_last                (rsp_last),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_ticks_per_decrement (csr_ticks_per_decrement),
      .head_rec                (ring[0]),
      .tail_rec                (tail_rec),
      .shift_en                (shift_en)
   );

endmodule

>>> src/stt_checker.sv
// ----------------------------------------------------------------------------
// Software timer table checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module stt_checker
   import stt_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [SLOT_W-1:0]   rsp_slot_out,
   input logic                rsp_fired,
   input logic                rsp_last
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_slot_out) && $stable(rsp_fired) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // one action at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an action is in progress");

   a_fired_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> rsp_status == STAT_OK)
      else $error("expired slot reported with error status");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_slot_out == '0 && !rsp_fired && rsp_last)
      else $error("error word carries slot or fired flag");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not idle after reset");

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);

>>> bench/software_timer_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table testbench
// Drives tick, start, stop, dispatch, clear and reserved action words through
// the request port, and mirrors the slot table in a scoreboard that predicts
// every result word. Response words are checked in order, field by field.
// The prescaler setting is changed between phases, including its extremes.
// The sender works in random bursts, and the receiver stalls on its own
// pattern, with long hold-offs that back the block up.
// ----------------------------------------------------------------------------

import stt_pkg::*;

typedef struct packed {
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_out;
   logic                fired;
   logic                last;
} timer_result_type;

class timer_slot_mirror_type;
   logic [SCALE_W-1:0] scale_setting;
   logic [SCALE_W-1:0] prescale;
   logic               busy      [MAX_TIMERS];
   logic [COUNT_W-1:0] remaining [MAX_TIMERS];
   logic [COUNT_W-1:0] reload    [MAX_TIMERS];
   logic               periodic  [MAX_TIMERS];
   timer_result_type   pending   [$];
   int unsigned        mismatches;
   int unsigned        actions_seen;
   int unsigned        words_checked;
   int unsigned        expiries;
   int unsigned        full_starts;

   function new();
      scale_setting = 8'd1;
      prescale      = '0;
      for (int i = 0; i < MAX_TIMERS; i++) begin
         busy[i]      = 1'b0;
         remaining[i] = '0;
         reload[i]    = '0;
         periodic[i]  = 1'b0;
      end
      mismatches    = 0;
      actions_seen  = 0;
      words_checked = 0;
      expiries      = 0;
      full_starts   = 0;
   endfunction

   function void set_scale(logic [SCALE_W-1:0] value);
      scale_setting = value;
   endfunction

   function int pending_count();
      return pending.size();
   endfunction

   function void push_word(logic [STATUS_W-1:0] status, int slot, logic fired,
                           logic last);
      timer_result_type word;
      word.status   = status;
      word.slot_out = SLOT_W'(slot);
      word.fired    = fired;
      word.last     = last;
      pending.push_back(word);
   endfunction

   // A setting of zero counts as one; the prescaler wraps on every decrement.
   function void advance_prescaler();
      logic [SCALE_W:0] next;
      logic [SCALE_W:0] limit;
      limit = (scale_setting == '0) ? (SCALE_W+1)'(1) : {1'b0, scale_setting};
      next  = {1'b0, prescale} + 1'b1;
      if (next >= limit) begin
         prescale = '0;
         for (int i = 0; i < MAX_TIMERS; i++)
            if (busy[i] && remaining[i] != '0)
               remaining[i] = remaining[i] - 1'b1;
      end else begin
         prescale = next[SCALE_W-1:0];
      end
   endfunction

   function void apply_action(logic [ACTION_W-1:0] act, logic [SLOT_W-1:0] sid,
                              logic [COUNT_W-1:0] dly, logic per);
      int idx;
      int fired_n;
      actions_seen++;
      case (act)
         ACT_TICK: begin
            advance_prescaler();
            push_word(STAT_OK, 0, 1'b0, 1'b1);
         end
         ACT_START: begin
            idx = -1;
            for (int i = 0; i < MAX_TIMERS; i++)
               if (!busy[i] && idx < 0)
                  idx = i;
            // full table wins over a zero delay
            if (idx < 0) begin
               full_starts++;
               push_word(STAT_FULL, 0, 1'b0, 1'b1);
            end else if (dly == '0) begin
               push_word(STAT_INVALID, 0, 1'b0, 1'b1);
            end else begin
               busy[idx]      = 1'b1;
               remaining[idx] = dly;
               reload[idx]    = dly;
               periodic[idx]  = per;
               push_word(STAT_OK, idx, 1'b0, 1'b1);
            end
         end
         ACT_STOP: begin
            if (busy[sid]) begin
               busy[sid] = 1'b0;
               push_word(STAT_OK, 0, 1'b0, 1'b1);
            end else begin
               push_word(STAT_INVALID, 0, 1'b0, 1'b1);
            end
         end
         ACT_DISPATCH: begin
            fired_n = 0;
            for (int i = 0; i < MAX_TIMERS; i++) begin
               if (busy[i] && remaining[i] == '0) begin
                  push_word(STAT_OK, i, 1'b1, 1'b0);
                  fired_n++;
                  remaining[i] = reload[i];
                  if (!periodic[i])
                     busy[i] = 1'b0;
               end
            end
            if (fired_n == 0)
               push_word(STAT_OK, 0, 1'b0, 1'b1);
            else
               pending[pending.size()-1].last = 1'b1;
            expiries += fired_n;
         end
         ACT_CLEAR: begin
            for (int i = 0; i < MAX_TIMERS; i++)
               busy[i] = 1'b0;
            push_word(STAT_OK, 0, 1'b0, 1'b1);
         end
         default: begin
            push_word(STAT_INVALID, 0, 1'b0, 1'b1);
         end
      endcase
   endfunction

   function int random_busy_slot();
      int count;
      int pick;
      count = 0;
      for (int i = 0; i < MAX_TIMERS; i++)
         if (busy[i])
            count++;
      if (count == 0)
         return -1;
      pick = $urandom_range(0, count - 1);
      for (int i = 0; i < MAX_TIMERS; i++) begin
         if (busy[i]) begin
            if (pick == 0)
               return i;
            pick--;
         end
      end
      return -1;
   endfunction

   function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function void compare_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                                logic fired, logic last);
      timer_result_type want;
      if (pending.size() == 0) begin
         $error("unexpected result word: status %0d slot %0d fired %0d last %0d",
                status, slot, fired, last);
         mismatches++;
         return;
      end
      want = pending.pop_front();
      words_checked++;
      check_field("status", 8'(want.status), 8'(status));
      check_field("slot_out", 8'(want.slot_out), 8'(slot));
      check_field("fired", 8'(want.fired), 8'(fired));
      check_field("last", 8'(want.last), 8'(last));
   endfunction
endclass

module software_timer_table_tb;

   localparam logic [ACTION_W-1:0] ACT_RESERVED_FIRST = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_RESERVED_LAST  = 3'd7;
   localparam int PHASE_COUNT  = 6;
   localparam int PHASE_WORDS  = 41;
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_HOLD    = 300;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action;
   logic [SLOT_W-1:0]   req_slot_id;
   logic [COUNT_W-1:0]  req_delay_value;
   logic                req_is_periodic;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_out;
   logic                rsp_fired;
   logic                rsp_last;
   logic                csr_valid;
   logic                csr_ready;
   logic [SCALE_W-1:0]  csr_ticks_per_decrement;

   timer_slot_mirror_type mirror;
   int                    burst_left;
   int                    settings_used;

   software_timer_table dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_action              (req_action),
      .req_slot_id             (req_slot_id),
      .req_delay_value         (req_delay_value),
      .req_is_periodic         (req_is_periodic),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_status              (rsp_status),
      .rsp_slot_out            (rsp_slot_out),
      .rsp_fired               (rsp_fired),
      .rsp_last                (rsp_last),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_ticks_per_decrement (csr_ticks_per_decrement)
   );

   always #2 clock = ~clock;

   // Offer one word; open a new burst with a random gap when the last one ran out.
   task automatic offer_request(input logic [ACTION_W-1:0] act,
                                input logic [SLOT_W-1:0] sid,
                                input logic [COUNT_W-1:0] dly, input logic per);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_action      <= act;
      req_slot_id     <= sid;
      req_delay_value <= dly;
      req_is_periodic <= per;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mirror.apply_action(act, sid, dly, per);
      burst_left--;
   endtask

   task automatic send_random_word();
      int                  pick;
      int                  slot_pick;
      logic [ACTION_W-1:0] act;
      logic [SLOT_W-1:0]   sid;
      logic [COUNT_W-1:0]  dly;
      logic                per;
      sid  = SLOT_W'($urandom_range(0, MAX_TIMERS - 1));
      dly  = COUNT_W'($urandom());
      per  = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         act = ACT_TICK;
      end else if (pick < 62) begin
         act = ACT_START;
         // mostly short delays so timers actually expire
         if ($urandom_range(0, 9) < 7)
            dly = COUNT_W'($urandom_range(1, 6));
         else if ($urandom_range(0, 9) == 0)
            dly = '0;
      end else if (pick < 80) begin
         act = ACT_DISPATCH;
      end else if (pick < 93) begin
         act = ACT_STOP;
         slot_pick = mirror.random_busy_slot();
         if (slot_pick >= 0 && $urandom_range(0, 3) != 0)
            sid = SLOT_W'(slot_pick);
      end else if (pick < 96) begin
         act = ACT_CLEAR;
      end else begin
         act = ACT_RESERVED_FIRST + ACTION_W'($urandom_range(0, 2));
      end
      offer_request(act, sid, dly, per);
   endtask

   // Drop valid, let every expected word arrive, then let the block settle.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (mirror.pending_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_scale(input logic [SCALE_W-1:0] value);
      @(negedge clock);
      csr_valid               <= 1'b1;
      csr_ticks_per_decrement <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mirror.set_scale(value);
      settings_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         mirror.compare_result(rsp_status, rsp_slot_out, rsp_fired, rsp_last);
   end

   // Receiver: segments of free flow, light and heavy stalling, and long holds.
   initial begin
      int seg;
      int seg_len;
      int mode;
      rsp_stall = 1'b0;
      seg = 0;
      forever begin
         if (seg == 2 || seg == 12) begin
            mode    = 3;
            seg_len = LONG_HOLD;
         end else begin
            mode    = $urandom_range(0, 2);
            seg_len = $urandom_range(20, 80);
         end
         repeat (seg_len) begin
            @(negedge clock);
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 1) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= 1'b1;
            endcase
         end
         seg++;
      end
   end

   initial begin
      #2000000;
      $display("timeout: %0d result words still expected", mirror.pending_count());
      $display("** software_timer_table: FAILED **");
      $finish;
   end

   initial begin
      logic [SCALE_W-1:0] scale_plan [PHASE_COUNT];
      clock                   = 1'b0;
      reset                   = 1'b1;
      req_valid               = 1'b0;
      req_action              = ACT_TICK;
      req_slot_id             = '0;
      req_delay_value         = '0;
      req_is_periodic         = 1'b0;
      csr_valid               = 1'b0;
      csr_ticks_per_decrement = '0;
      burst_left              = 0;
      settings_used           = 0;
      mirror                  = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_scale(8'd1);

      // Directed: empty table, fill it, overflow, expire, stop, reserved, clear.
      offer_request(ACT_TICK,     3'd0, 16'd0,      1'b0);
      offer_request(ACT_DISPATCH, 3'd0, 16'd0,      1'b0);
      offer_request(ACT_STOP,     3'd3, 16'd0,      1'b0);
      offer_request(ACT_START,    3'd0, 16'd0,      1'b1);
      offer_request(ACT_START,    3'd0, 16'd1,      1'b1);
      offer_request(ACT_START,    3'd0, 16'hFFFF,   1'b0);
      offer_request(ACT_START,    3'd0, 16'd2,      1'b0);
      offer_request(ACT_START,    3'd0, 16'd3,      1'b1);
      offer_request(ACT_START,    3'd0, 16'hAAAA,   1'b1);
      offer_request(ACT_START,    3'd0, 16'h5555,   1'b0);
      offer_request(ACT_START,    3'd0, 16'd1,      1'b0);
      offer_request(ACT_START,    3'd0, 16'd2,      1'b1);
      offer_request(ACT_START,    3'd0, 16'd5,      1'b0);
      offer_request(ACT_START,    3'd0, 16'd0,      1'b0);
      offer_request(ACT_TICK,     3'd7, 16'hFFFF,   1'b1);
      offer_request(ACT_TICK,     3'd0, 16'd0,      1'b0);
      offer_request(ACT_TICK,     3'd0, 16'd0,      1'b0);
      offer_request(ACT_DISPATCH, 3'd0, 16'd0,      1'b0);
      offer_request(ACT_STOP,     3'd1, 16'd0,      1'b0);
      offer_request(ACT_STOP,     3'd1, 16'd0,      1'b0);
      offer_request(ACT_RESERVED_FIRST, 3'd0, 16'd0, 1'b0);
      offer_request(ACT_RESERVED_LAST,  3'd7, 16'hFFFF, 1'b1);
      offer_request(ACT_CLEAR,    3'd0, 16'd0,      1'b0);
      offer_request(ACT_DISPATCH, 3'd0, 16'd0,      1'b0);
      offer_request(ACT_TICK,     3'd0, 16'd0,      1'b0);
      drain();

      scale_plan = '{8'd0, 8'd2, 8'd255, 8'd3, 8'd1, 8'd4};
      scale_plan[4] = SCALE_W'($urandom_range(1, 6));
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_scale(scale_plan[p]);
         repeat (PHASE_WORDS) send_random_word();
         drain();
      end

      $display("Covered %0d action words and %0d result words over %0d prescaler settings,",
               mirror.actions_seen, mirror.words_checked, settings_used);
      $display("with %0d timer expiries and %0d starts refused by a full table.",
               mirror.expiries, mirror.full_starts);
      if (mirror.mismatches == 0 && mirror.pending_count() == 0)
         $display("** software_timer_table: PASSED **");
      else
         $display("** software_timer_table: FAILED **");
      $finish;
   end

endmodule
